>>> src/sli_pkg.sv
`default_nettype none

package sli_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT    = 2'd0,
    FUNC_DELETE    = 2'd1,
    FUNC_DUMP_ASC  = 2'd2,
    FUNC_DUMP_DESC = 2'd3
  } func_e;

  localparam logic [2:0] STS_INSERTED = 3'd0;
  localparam logic [2:0] STS_DELETED  = 3'd1;
  localparam logic [2:0] STS_NOTFOUND = 3'd2;
  localparam logic [2:0] STS_FULL     = 3'd3;
  localparam logic [2:0] STS_ELEMENT  = 3'd4;
  localparam logic [2:0] STS_EMPTY    = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DEL_RD,
    ST_DEL_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_DMP_RD,
    ST_DMP_OUT,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

>>> src/sorted_list_insert_delete.sv
`default_nettype none

// channel | valid      | stall      | payload
// --------+------------+------------+------------------------------------
// in      | in_valid_i | in_stall_o | func_i, value_i
// out     | out_valid_o| out_stall_i| value_res_o, status_o, last_o
//
// one item at a time; a shared compare unit walks the store through a single
// registered read port, a read and then a compare or write for each entry touched
// insert shifts entries up from the top, delete scans from the bottom and then
// shifts the entries above down, dump reads and emits each element in turn
// reset empties the list at once (count cleared, store contents left as is)
// an out stall only holds the sequencer when a new result must be loaded

module sorted_list_insert_delete #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         func_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      value_res_o,
  output logic [2:0]              status_o,
  output logic                    last_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // sorted store, ascending in entries below the count
  logic signed [31:0] mem_q [CAPACITY];
  logic signed [31:0] rdata_q;
  logic               rd_en;
  logic [IW-1:0]      raddr;
  logic               wr_en;
  logic [IW-1:0]      waddr;
  logic signed [31:0] wdata;

  sli_pkg::state_e    state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic signed [31:0] val_q, val_d;
  logic [2:0]         sts_q, sts_d;
  logic               desc_q, desc_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_value_q, out_value_d;
  logic [2:0]         out_status_q, out_status_d;
  logic               out_last_q, out_last_d;

  logic               can_load;
  logic [CW-1:0]      idx_inc;
  logic [CW-1:0]      idx_dec;
  logic [CW-1:0]      dmp_addr;
  logic               rd_less;
  sli_pkg::func_e     func_in;

  assign func_in  = sli_pkg::func_e'(func_i);
  assign can_load = !out_valid_q || !out_stall_i;
  assign idx_inc  = idx_q + ONE_C;
  assign idx_dec  = idx_q - ONE_C;
  assign dmp_addr = desc_q ? (cnt_q - ONE_C - idx_q) : idx_q;
  // the one compare unit, shared by the insert and delete walks over the store
  assign rd_less  = rdata_q < val_q;

  assign in_stall_o  = (state_q != sli_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_res_o = out_value_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sli_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    val_q        <= val_d;
    sts_q        <= sts_d;
    desc_q       <= desc_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    val_d        = val_q;
    sts_d        = sts_q;
    desc_d       = desc_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    raddr        = idx_q[IW-1:0];
    wr_en        = 1'b0;
    waddr        = idx_q[IW-1:0];
    wdata        = val_q;

    unique case (state_q)
      sli_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          val_d  = value_i;
          idx_d  = '0;
          desc_d = (func_in == sli_pkg::FUNC_DUMP_DESC);
          unique case (func_in) inside
            sli_pkg::FUNC_INSERT: begin
              if (cnt_q == CAP_C) begin
                sts_d   = sli_pkg::STS_FULL;
                state_d = sli_pkg::ST_RESP;
              end else begin
                // walk down from the top, shifting up what is not below value
                idx_d   = cnt_q;
                state_d = sli_pkg::ST_INS_RD;
              end
            end
            sli_pkg::FUNC_DELETE: begin
              state_d = sli_pkg::ST_DEL_RD;
            end
            sli_pkg::FUNC_DUMP_ASC, sli_pkg::FUNC_DUMP_DESC: begin
              if (cnt_q == '0) begin
                sts_d   = sli_pkg::STS_EMPTY;
                state_d = sli_pkg::ST_RESP;
              end else begin
                state_d = sli_pkg::ST_DMP_RD;
              end
            end
            default: state_d = sli_pkg::ST_IDLE;
          endcase
        end
      end

      sli_pkg::ST_INS_RD: begin
        if (idx_q == '0) begin
          // reached the bottom: value goes into entry zero
          wr_en   = 1'b1;
          cnt_d   = cnt_q + ONE_C;
          sts_d   = sli_pkg::STS_INSERTED;
          state_d = sli_pkg::ST_RESP;
        end else begin
          rd_en   = 1'b1;
          raddr   = idx_dec[IW-1:0];
          state_d = sli_pkg::ST_INS_CMP;
        end
      end

      sli_pkg::ST_INS_CMP: begin
        wr_en = 1'b1;
        if (!rd_less) begin
          // equal or greater entries move up, so the new value lands first
          wdata   = rdata_q;
          idx_d   = idx_dec;
          state_d = sli_pkg::ST_INS_RD;
        end else begin
          cnt_d   = cnt_q + ONE_C;
          sts_d   = sli_pkg::STS_INSERTED;
          state_d = sli_pkg::ST_RESP;
        end
      end

      sli_pkg::ST_DEL_RD: begin
        if (idx_q == cnt_q) begin
          sts_d   = sli_pkg::STS_NOTFOUND;
          state_d = sli_pkg::ST_RESP;
        end else begin
          rd_en   = 1'b1;
          state_d = sli_pkg::ST_DEL_CMP;
        end
      end

      sli_pkg::ST_DEL_CMP: begin
        if (rd_less) begin
          idx_d   = idx_inc;
          state_d = sli_pkg::ST_DEL_RD;
        end else if (rdata_q == val_q) begin
          state_d = sli_pkg::ST_SH_RD;
        end else begin
          sts_d   = sli_pkg::STS_NOTFOUND;
          state_d = sli_pkg::ST_RESP;
        end
      end

      sli_pkg::ST_SH_RD: begin
        if (idx_inc >= cnt_q) begin
          cnt_d   = cnt_q - ONE_C;
          sts_d   = sli_pkg::STS_DELETED;
          state_d = sli_pkg::ST_RESP;
        end else begin
          rd_en   = 1'b1;
          raddr   = idx_inc[IW-1:0];
          state_d = sli_pkg::ST_SH_WR;
        end
      end

      sli_pkg::ST_SH_WR: begin
        wr_en   = 1'b1;
        wdata   = rdata_q;
        idx_d   = idx_inc;
        state_d = sli_pkg::ST_SH_RD;
      end

      sli_pkg::ST_DMP_RD: begin
        rd_en   = 1'b1;
        raddr   = dmp_addr[IW-1:0];
        state_d = sli_pkg::ST_DMP_OUT;
      end

      sli_pkg::ST_DMP_OUT: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_value_d  = rdata_q;
          out_status_d = sli_pkg::STS_ELEMENT;
          out_last_d   = (idx_inc == cnt_q);
          idx_d        = idx_inc;
          state_d      = (idx_inc == cnt_q) ? sli_pkg::ST_IDLE : sli_pkg::ST_DMP_RD;
        end
      end

      sli_pkg::ST_RESP: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_value_d  = (sts_q == sli_pkg::STS_EMPTY) ? 32'sd0 : val_q;
          out_status_d = sts_q;
          out_last_d   = 1'b1;
          state_d      = sli_pkg::ST_IDLE;
        end
      end

      default: state_d = sli_pkg::ST_IDLE;
    endcase
  end

  // count stays within the store
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP_C)
    else $error("element count beyond capacity");

  // the count moves only on the way to a single result
  a_cnt_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> state_q == sli_pkg::ST_RESP)
    else $error("element count changed outside insert or delete completion");

  // full is only reported with a full store
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sli_pkg::ST_RESP && sts_q == sli_pkg::STS_FULL) |-> cnt_q == CAP_C)
    else $error("full reported on a store with room");

  // a dump never walks past the held elements
  a_dump_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sli_pkg::ST_DMP_RD || state_q == sli_pkg::ST_DMP_OUT) |-> idx_q < cnt_q)
    else $error("dump index past element count");

endmodule

`default_nettype wire
